// File: rtl/core/sem_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the Sobel edge magnitude block.
// ---------------------------------------------------------------------------
package sem_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int QDEPTH        = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [15:0] HEIGHT_RST = 16'd480;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } in_t;

  typedef struct packed {
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic       frame_end;
  } out_t;

  // Window entries: index row*3+col, pixel packed as R, G, B from the top.
  typedef logic [8:0][23:0] win_t;

  typedef struct packed {
    win_t win;
    logic frame_end;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage : sem_pkg
`default_nettype wire

// File: rtl/core/sobel_edge_magnitude.sv
// A request that completes a window is staged in the front, queued as a job
// and taken by the back when idle; its result is loaded once the result
// port is free. The front takes no request while one is staged or the queue
// is full; the back finds its root one bit a cycle and takes no new job until
// its result is loaded. Reset is synchronous and active low; registers return
// to 640 x 480, position zero, window zero; the row store needs no clearing.
`default_nettype none
// ---------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel edge magnitude over RGB frames in raster order.
// ---------------------------------------------------------------------------
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire sem_pkg::in_t                   in_data,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output sem_pkg::out_t                       out_data,
  input  wire logic                           cfg_we,
  input  wire logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sem_pkg::*;

  logic    q_push, q_pop;
  job_t    q_in, q_out;
  q_stat_t q_stat;

  sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_job     (q_in),
    .q_stat    (q_stat)
  );

  sem_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  sem_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_pop     (q_pop),
    .q_job     (q_out),
    .q_stat    (q_stat),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule : sobel_edge_magnitude
`default_nettype wire

// File: rtl/core/sem_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sem_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule : sem_ram
`default_nettype wire

// File: rtl/core/sem_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sem_queue
// Short queue of window jobs between the front and the back.
// ---------------------------------------------------------------------------
module sem_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire sem_pkg::job_t    push_data,
  input  wire logic             pop,
  output sem_pkg::job_t         pop_data,
  output sem_pkg::q_stat_t      stat
);
  import sem_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  job_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == CNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_r];

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule : sem_queue
`default_nettype wire

// File: rtl/core/sem_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sem_front
// Accepts pixel and drain requests, keeps the raster position, the row
// stores and the 3x3 window, and queues one window job per result.
// ---------------------------------------------------------------------------
module sem_front #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_push,
  output logic                                    in_full,
  input  wire sem_pkg::in_t                       in_data,
  input  wire logic                               cfg_we,
  input  wire logic [sem_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sem_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                    q_push,
  output sem_pkg::job_t                           q_job,
  input  wire sem_pkg::q_stat_t                   q_stat
);
  import sem_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);

  logic [10:0]       width_r;
  logic [15:0]       height_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [16:0]       row_r, row_nxt;
  win_t              win_r, win_nxt;
  logic              stage_valid_r;
  in_t               st_r;

  logic [WCNT_W-1:0] eff_w;
  logic [16:0]       h17;
  logic              accept, cfg_hit;
  logic [47:0]       ram_rdata, ram_wdata;
  logic              ram_we;
  logic [23:0]       px, top, mid;
  win_t              rz_win;

  assign eff_w = (width_r == '0) ? WCNT_W'(1) :
                 (32'(width_r) > MAX_WIDTH) ? WCNT_W'(MAX_WIDTH) : WCNT_W'(width_r);
  assign h17   = (height_r == '0) ? 17'd1 : {1'b0, height_r};

  assign in_full = stage_valid_r || q_stat.full;
  assign accept  = in_push && !in_full;
  assign cfg_hit = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);

  // Each entry holds {previous row, row before it} for one column.
  sem_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_r),
    .wdata (ram_wdata),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign px  = (row_r < h17) ? {st_r.pixel_red, st_r.pixel_green, st_r.pixel_blue} : 24'd0;
  assign mid = (row_r >= 17'd1) ? ram_rdata[47:24] : 24'd0;
  assign top = (row_r >= 17'd2) ? ram_rdata[23:0] : 24'd0;
  assign ram_wdata = {px, mid};

  always_comb begin
    rz_win    = win_r;
    rz_win[2] = '0;
    rz_win[5] = '0;
    rz_win[8] = '0;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    win_nxt = win_r;
    q_push  = 1'b0;
    q_job   = '0;
    ram_we  = 1'b0;
    if (stage_valid_r) begin
      if (row_r >= h17 + 17'd1) begin
        q_push         = 1'b1;
        q_job.win      = rz_win;
        q_job.frame_end = 1'b1;
        col_nxt        = '0;
        row_nxt        = '0;
      end else if (!(row_r < h17 && st_r.req_type == REQ_DRAIN)) begin
        ram_we = 1'b1;
        if (col_r == '0) begin
          for (int i = 0; i < 3; i++) begin
            win_nxt[i*3]   = '0;
            win_nxt[i*3+1] = '0;
          end
          // The row that just ended is finished with its right border zeroed.
          if (row_r >= 17'd2) begin
            q_push    = 1'b1;
            q_job.win = rz_win;
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            win_nxt[i*3]   = win_r[i*3+1];
            win_nxt[i*3+1] = win_r[i*3+2];
          end
        end
        win_nxt[2] = top;
        win_nxt[5] = mid;
        win_nxt[8] = px;
        if (col_r != '0 && row_r >= 17'd1) begin
          q_push    = 1'b1;
          q_job.win = win_nxt;
        end
        if (WCNT_W'(col_r) + 1'b1 >= eff_w) begin
          col_nxt = '0;
          row_nxt = row_r + 17'd1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
    end
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r       <= WIDTH_RST;
      height_r      <= HEIGHT_RST;
      col_r         <= '0;
      row_r         <= '0;
      win_r         <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_WIDTH) begin
        width_r <= cfg_data[10:0];
      end
      if (cfg_we && cfg_index == CFG_HEIGHT) begin
        height_r <= cfg_data;
      end
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      win_r         <= win_nxt;
      stage_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r <= in_data;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  a_stage_one: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r |=> !stage_valid_r)
    else $error("front stage held for more than one cycle");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid_r && row_r >= h17 + 17'd1) |=> (row_r == '0 && col_r == '0))
    else $error("position did not return to zero after frame end");

endmodule : sem_front
`default_nettype wire

// File: rtl/core/sem_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sem_back
// Computes Gx and Gy per channel from a window job, squares them and finds
// the rounded, clamped root one bit per cycle into the result register.
// ---------------------------------------------------------------------------
module sem_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  output logic                   q_pop,
  input  wire sem_pkg::job_t     q_job,
  input  wire sem_pkg::q_stat_t  q_stat,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output sem_pkg::out_t          out_data
);
  import sem_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_SUM  = 5'b00010,
    B_SQ   = 5'b00100,
    B_ITER = 5'b01000,
    B_DONE = 5'b10000
  } bstate_t;

  bstate_t            state_r, state_nxt;
  job_t               job_r;
  logic [2:0][9:0]    ax_r, ay_r, ax_c, ay_c;
  logic [2:0][20:0]   s_r;
  logic [2:0][7:0]    k_r;
  logic [2:0]         bit_r;
  logic               out_valid_r;
  out_t               out_r;
  logic               load_out;

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign q_pop     = (state_r == B_IDLE) && !q_stat.empty;
  assign load_out  = (state_r == B_DONE) && (!out_valid_r || out_pop);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic signed [11:0] v [9];
      logic signed [11:0] gx, gy;
      for (int i = 0; i < 9; i++) begin
        v[i] = $signed({4'd0, job_r.win[i][23-8*ch -: 8]});
      end
      gx = (v[2] + 12'sd2 * v[5] + v[8]) - (v[0] + 12'sd2 * v[3] + v[6]);
      gy = (v[6] + 12'sd2 * v[7] + v[8]) - (v[0] + 12'sd2 * v[1] + v[2]);
      ax_c[ch] = gx[11] ? 10'(-gx) : 10'(gx);
      ay_c[ch] = gy[11] ? 10'(-gy) : 10'(gy);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (!q_stat.empty) state_nxt = B_SUM;
      B_SUM:   state_nxt = B_SQ;
      B_SQ:    state_nxt = B_ITER;
      B_ITER:  if (bit_r == 3'd0) state_nxt = B_DONE;
      B_DONE:  if (load_out) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The largest k with k*(k-1) below the sum of squares is the rounded root.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (state_r == B_SUM) begin
      ax_r <= ax_c;
      ay_r <= ay_c;
    end
    if (state_r == B_SQ) begin
      for (int ch = 0; ch < 3; ch++) begin
        s_r[ch] <= {11'd0, ax_r[ch]} * {11'd0, ax_r[ch]}
                 + {11'd0, ay_r[ch]} * {11'd0, ay_r[ch]};
        k_r[ch] <= '0;
      end
      bit_r <= 3'd7;
    end
    if (state_r == B_ITER) begin
      for (int ch = 0; ch < 3; ch++) begin
        logic [7:0]  t;
        logic [15:0] prod;
        t    = k_r[ch] | (8'd1 << bit_r);
        prod = t * (t - 8'd1);
        if ({5'd0, prod} < s_r[ch]) begin
          k_r[ch] <= t;
        end
      end
      bit_r <= bit_r - 3'd1;
    end
    if (load_out) begin
      out_r.edge_red   <= k_r[0];
      out_r.edge_green <= k_r[1];
      out_r.edge_blue  <= k_r[2];
      out_r.frame_end  <= job_r.frame_end;
    end
  end

endmodule : sem_back
`default_nettype wire
